@@ src/bpra_pkg.sv @@
// Package for the bitmap page run allocator: sizes, item types.
package bpra_pkg;

   // Block geometry
   localparam int PAGES    = 64;
   localparam int PAGE_W   = $clog2(PAGES);
   localparam int COUNT_W  = $clog2(PAGES + 1);
   localparam int RUN_MAX  = PAGES / 2;

   // Fixed field widths of the item interface
   localparam int KIND_W   = 1;
   localparam int RUN_W    = 6;
   localparam int IDX_W    = 6;
   localparam int TOTAL_W  = 7;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [RUN_W-1:0]  run_pages;
      logic [IDX_W-1:0]  free_index;
   } bpra_req_type;

   typedef struct packed {
      logic               ok;
      logic [IDX_W-1:0]   start_index;
      logic [RUN_W-1:0]   freed_pages;
      logic [TOTAL_W-1:0] pages_free;
   } bpra_rsp_type;

endpackage

@@ src/bpra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bitmap_page_run_allocator_core.sv @@
// Top level: first-fit page run allocator over one block, page-serial sequencer.
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_item          in         transfer when start & !busy
//  result    rsp_valid, rsp_item            out        one-cycle strobe, no backpressure
//
// Steps: an allocate walks the used map one page per cycle to find the lowest free run,
// then marks its pages one per cycle. A free reads the run length RAM in ST_FREAD, then
// releases one page per cycle. A rejected allocate (zero or oversized) answers from
// ST_IDLE without going busy. The single page walk counter serves one request at a time.
// The result strobe comes in the cycle after the last step, when busy is already low.
// Reset: all pages free, no runs recorded, free count PAGES; no clearing pass is needed.
module bitmap_page_run_allocator_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bpra_pkg::bpra_req_type req_item,
   output logic                  rsp_valid,
   output bpra_pkg::bpra_rsp_type rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREAD,
      ST_WALK
   } state_type;

   state_type                       state_ff, state_in;
   logic [bpra_pkg::PAGE_W-1:0]     page_ff, page_in;
   logic [bpra_pkg::RUN_W-1:0]      cnt_ff, cnt_in;
   logic                            set_ff, set_in;
   logic [bpra_pkg::PAGES-1:0]      used_map_ff, used_map_in;
   logic [bpra_pkg::PAGES-1:0]      valid_ff, valid_in;
   logic [bpra_pkg::COUNT_W-1:0]    free_total_ff, free_total_in;
   bpra_pkg::bpra_req_type          req_ff, req_in;
   logic                            ok_ff, ok_in;
   logic [bpra_pkg::PAGE_W-1:0]     start_ff, start_in;
   logic [bpra_pkg::RUN_W-1:0]      freed_ff, freed_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            ram_we;
   logic [bpra_pkg::PAGE_W-1:0]     ram_waddr;
   logic [bpra_pkg::PAGE_W-1:0]     ram_raddr;
   logic [bpra_pkg::RUN_W-1:0]      ram_rdata;

   logic                            accept;
   logic [bpra_pkg::COUNT_W-1:0]    free_sum;

   // run length store; valid bits below stand for its reset
   bpra_ram #(
      .WIDTH (bpra_pkg::RUN_W),
      .DEPTH (bpra_pkg::PAGES)
   ) u_run_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ff.run_pages),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign ram_raddr = bpra_pkg::PAGE_W'(req_item.free_index);
   assign free_sum  = free_total_ff + bpra_pkg::COUNT_W'(ram_rdata);

   // sequencer next-state logic
   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      cnt_in        = cnt_ff;
      set_in        = set_ff;
      used_map_in   = used_map_ff;
      valid_in      = valid_ff;
      free_total_in = free_total_ff;
      req_in        = req_ff;
      ok_in         = ok_ff;
      start_in      = start_ff;
      freed_in      = freed_ff;
      rsp_valid_in  = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = page_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               ok_in    = 1'b0;
               start_in = '0;
               freed_in = '0;
               page_in  = '0;
               cnt_in   = '0;
               if (req_item.kind == bpra_pkg::KIND_FREE) begin
                  state_in = ST_FREAD;
               end else if (req_item.run_pages != '0 &&
                            bpra_pkg::COUNT_W'(req_item.run_pages) <=
                            bpra_pkg::COUNT_W'(bpra_pkg::RUN_MAX)) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end

         // one page per cycle, count consecutive free pages
         ST_SCAN: begin
            if (used_map_ff[page_ff]) begin
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + bpra_pkg::RUN_W'(1);
            end
            if (!used_map_ff[page_ff] &&
                (cnt_ff + bpra_pkg::RUN_W'(1)) == req_ff.run_pages) begin
               // run found: record it, then mark pages from its start
               start_in      = page_ff - bpra_pkg::PAGE_W'(req_ff.run_pages)
                               + bpra_pkg::PAGE_W'(1);
               page_in       = start_in;
               cnt_in        = req_ff.run_pages;
               set_in        = 1'b1;
               ok_in         = 1'b1;
               ram_we        = 1'b1;
               ram_waddr     = start_in;
               valid_in[start_in] = 1'b1;
               free_total_in = free_total_ff - bpra_pkg::COUNT_W'(req_ff.run_pages);
               state_in      = ST_WALK;
            end else if (page_ff == bpra_pkg::PAGE_W'(bpra_pkg::PAGES - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               page_in = page_ff + bpra_pkg::PAGE_W'(1);
            end
         end

         // run length read is back; release if a run starts here
         ST_FREAD: begin
            if (bpra_pkg::COUNT_W'(req_ff.free_index) < bpra_pkg::COUNT_W'(bpra_pkg::PAGES)
                && valid_ff[bpra_pkg::PAGE_W'(req_ff.free_index)]
                && ram_rdata != '0) begin
               page_in  = bpra_pkg::PAGE_W'(req_ff.free_index);
               cnt_in   = ram_rdata;
               set_in   = 1'b0;
               ok_in    = 1'b1;
               freed_in = ram_rdata;
               valid_in[bpra_pkg::PAGE_W'(req_ff.free_index)] = 1'b0;
               if (free_sum > bpra_pkg::COUNT_W'(bpra_pkg::PAGES)) begin
                  free_total_in = bpra_pkg::COUNT_W'(bpra_pkg::PAGES);
               end else begin
                  free_total_in = free_sum;
               end
               state_in = ST_WALK;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         // set or clear one page per cycle
         ST_WALK: begin
            used_map_in[page_ff] = set_ff;
            cnt_in  = cnt_ff - bpra_pkg::RUN_W'(1);
            page_in = page_ff + bpra_pkg::PAGE_W'(1);
            if (cnt_ff == bpra_pkg::RUN_W'(1) ||
                page_ff == bpra_pkg::PAGE_W'(bpra_pkg::PAGES - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_map_ff   <= '0;
         valid_ff      <= '0;
         free_total_ff <= bpra_pkg::COUNT_W'(bpra_pkg::PAGES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_map_ff   <= used_map_in;
         valid_ff      <= valid_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      page_ff  <= page_in;
      cnt_ff   <= cnt_in;
      set_ff   <= set_in;
      req_ff   <= req_in;
      ok_ff    <= ok_in;
      start_ff <= start_in;
      freed_ff <= freed_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_item.ok          = ok_ff;
   assign rsp_item.start_index = bpra_pkg::IDX_W'(start_ff);
   assign rsp_item.freed_pages = freed_ff;
   assign rsp_item.pages_free  = bpra_pkg::TOTAL_W'(free_total_ff);

   // result strobe only once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobe while sequencer busy");

   // an accepted transfer either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_valid_ff)
      else $error("accepted transfer dropped");

   // free count agrees with the used map whenever idle
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |->
         ($countones(used_map_ff) + int'(free_total_ff)) == bpra_pkg::PAGES)
      else $error("free count and used map disagree");

   // released pages imply success
   a_freed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && freed_ff != '0 |-> ok_ff)
      else $error("pages freed without ok");

   // every recorded run start is a used page
   a_valid_used: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (valid_ff & ~used_map_ff) == '0)
      else $error("recorded run starts on a free page");

endmodule

@@ dv/bitmap_page_run_allocator_core_test.sv @@
// Self-checking test of the first-fit page run allocator: directed table, then random traffic.
module bitmap_page_run_allocator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One row of the directed table: request plus an optional hand-written response
   typedef struct {
      bpra_pkg::bpra_req_type item;
      bit                     pinned;
      bpra_pkg::bpra_rsp_type rsp;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   bpra_pkg::bpra_req_type req_item;
   logic                   rsp_valid;
   bpra_pkg::bpra_rsp_type rsp_item;

   // Hand-written response that travels with the current request, if any
   bit                     pin_valid;
   bpra_pkg::bpra_rsp_type pin_rsp;

   // Allocator bookkeeping mirrored by the testbench
   logic [bpra_pkg::PAGES-1:0]   used_pages;
   logic [bpra_pkg::RUN_W-1:0]   run_len_at [bpra_pkg::PAGES];
   logic [bpra_pkg::TOTAL_W-1:0] pages_left;

   bpra_pkg::bpra_rsp_type pending_rsp [$];
   int                     mismatches;
   int                     gap_pct;

   bitmap_page_run_allocator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Apply one request to the bookkeeping and return the response it should produce
   function automatic bpra_pkg::bpra_rsp_type book_update(input bpra_pkg::bpra_req_type item);
      bpra_pkg::bpra_rsp_type     r;
      logic [bpra_pkg::PAGES-1:0] span;
      int                         len;
      int                         idx;
      r = '0;
      if (item.kind == bpra_pkg::KIND_ALLOC) begin
         if (item.run_pages != 0 && item.run_pages <= bpra_pkg::RUN_MAX) begin
            span = '0;
            for (int i = 0; i < item.run_pages; i++) span[i] = 1'b1;
            // lowest start where the whole span is free
            for (int s = 0; s + item.run_pages <= bpra_pkg::PAGES; s++) begin
               if ((used_pages & (span << s)) == '0) begin
                  used_pages    = used_pages | (span << s);
                  run_len_at[s] = item.run_pages;
                  pages_left    = pages_left - bpra_pkg::TOTAL_W'(item.run_pages);
                  r.ok          = 1'b1;
                  r.start_index = bpra_pkg::IDX_W'(s);
                  break;
               end
            end
         end
      end else begin
         idx = item.free_index;
         if (idx < bpra_pkg::PAGES && run_len_at[idx] != 0) begin
            len = run_len_at[idx];
            for (int i = 0; i < len && idx + i < bpra_pkg::PAGES; i++)
               used_pages[idx + i] = 1'b0;
            run_len_at[idx] = '0;
            pages_left = pages_left + bpra_pkg::TOTAL_W'(len);
            if (pages_left > bpra_pkg::PAGES) pages_left = bpra_pkg::TOTAL_W'(bpra_pkg::PAGES);
            r.ok          = 1'b1;
            r.freed_pages = bpra_pkg::RUN_W'(len);
         end
      end
      r.pages_free = pages_left;
      return r;
   endfunction

   task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Result checking and prediction at each transfer
   always @(posedge clock) begin
      bpra_pkg::bpra_rsp_type want;
      bpra_pkg::bpra_rsp_type predicted;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               field_check("ok", 8'(want.ok), 8'(rsp_item.ok));
               field_check("start_index", 8'(want.start_index), 8'(rsp_item.start_index));
               field_check("freed_pages", 8'(want.freed_pages), 8'(rsp_item.freed_pages));
               field_check("pages_free", 8'(want.pages_free), 8'(rsp_item.pages_free));
            end
         end
         if (start && !busy) begin
            predicted = book_update(req_item);
            pending_rsp.push_back(pin_valid ? pin_rsp : predicted);
         end
      end
   end

   // Present one request at a falling edge, hold it until taken; returns at a falling edge
   task automatic send_item(input bpra_pkg::bpra_req_type item, input bit pinned,
                            input bpra_pkg::bpra_rsp_type pin);
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start     <= 1'b1;
      req_item  <= item;
      pin_valid <= pinned;
      pin_rsp   <= pin;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic plan_row_type mk_row(input logic [bpra_pkg::KIND_W-1:0] kind,
                                           input int run, input int idx, input bit pinned,
                                           input bit ok, input int st, input int fr,
                                           input int pf);
      plan_row_type row;
      row.item.kind        = kind;
      row.item.run_pages   = bpra_pkg::RUN_W'(run);
      row.item.free_index  = bpra_pkg::IDX_W'(idx);
      row.pinned           = pinned;
      row.rsp.ok           = ok;
      row.rsp.start_index  = bpra_pkg::IDX_W'(st);
      row.rsp.freed_pages  = bpra_pkg::RUN_W'(fr);
      row.rsp.pages_free   = bpra_pkg::TOTAL_W'(pf);
      return row;
   endfunction

   initial begin
      plan_row_type           plan [$];
      bpra_pkg::bpra_req_type item;
      int                     live [$];
      int                     sel;
      int                     waited;

      start      = 1'b0;
      req_item   = '0;
      pin_valid  = 1'b0;
      pin_rsp    = '0;
      reset      = 1'b1;
      mismatches = 0;
      gap_pct    = 29;
      used_pages = '0;
      pages_left = bpra_pkg::TOTAL_W'(bpra_pkg::PAGES);
      foreach (run_len_at[i]) run_len_at[i] = '0;

      // Directed table
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC,  0,  0, 1, 0,  0,  0, 64)); // zero-page
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC, 33,  0, 1, 0,  0,  0, 64)); // oversized
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC, 63, 63, 1, 0,  0,  0, 64)); // all ones
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0,  0, 1, 0,  0,  0, 64)); // empty index
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,  63, 63, 1, 0,  0,  0, 64)); // empty top
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC, 32,  0, 1, 1,  0,  0, 32)); // largest run
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC, 32,  0, 1, 1, 32,  0,  0)); // block full
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC,  1,  0, 1, 0,  0,  0,  0)); // no fit
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0,  5, 1, 0,  0,  0,  0)); // inside a run
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0, 32, 1, 1,  0, 32, 32));
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0, 32, 1, 0,  0,  0, 32)); // double free
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC,  1,  0, 0, 0,  0,  0,  0));
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC,  1,  0, 0, 0,  0,  0,  0));
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC, 30,  0, 0, 0,  0,  0,  0));
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0, 33, 0, 0,  0,  0,  0)); // one-page hole
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC,  2,  0, 0, 0,  0,  0,  0)); // hole too small
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC,  1,  0, 0, 0,  0,  0,  0)); // fills the hole
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0,  0, 1, 1,  0, 32, 32));
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0, 34, 1, 1,  0, 30, 62));
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0, 32, 1, 1,  0,  1, 63));
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0, 33, 1, 1,  0,  1, 64));
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC, 31,  0, 1, 1,  0,  0, 33));
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC, 32,  0, 1, 1, 31,  0,  1));
      plan.push_back(mk_row(bpra_pkg::KIND_ALLOC,  1,  0, 1, 1, 63,  0,  0)); // last page
      plan.push_back(mk_row(bpra_pkg::KIND_FREE,   0, 63, 1, 1,  0,  1,  1)); // top index

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].item, plan[i].pinned, plan[i].rsp);

      // Random traffic in three idle profiles: light, heavy, none
      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 29 : (phase == 1) ? 75 : 0;
         repeat (450) begin
            item.kind       = bpra_pkg::KIND_ALLOC;
            item.run_pages  = bpra_pkg::RUN_W'($urandom_range(0, 63));
            item.free_index = bpra_pkg::IDX_W'($urandom_range(0, 63));
            sel = $urandom_range(0, 99);
            live.delete();
            for (int i = 0; i < bpra_pkg::PAGES; i++) if (run_len_at[i] != 0) live.push_back(i);
            if (sel < 42) begin
               // well-formed allocate, mostly small runs
               sel = $urandom_range(0, 99);
               item.run_pages = bpra_pkg::RUN_W'((sel < 70) ? $urandom_range(1, 8) :
                                (sel < 95) ? $urandom_range(9, bpra_pkg::RUN_MAX) :
                                bpra_pkg::RUN_MAX);
            end else if (sel < 80) begin
               // free a run that is really there, when one exists
               item.kind = bpra_pkg::KIND_FREE;
               if (live.size() != 0)
                  item.free_index = bpra_pkg::IDX_W'(live[$urandom_range(0, live.size() - 1)]);
            end else if (sel < 85) begin
               item.run_pages = '0;
            end else if (sel < 90) begin
               item.run_pages = bpra_pkg::RUN_W'($urandom_range(bpra_pkg::RUN_MAX + 1, 63));
            end else begin
               // stray free at a random index: empty, inside a run or a run start
               item.kind = bpra_pkg::KIND_FREE;
            end
            send_item(item, 1'b0, '0);
         end
      end
      start <= 1'b0;

      // Drain
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         if (pending_rsp.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, pending_rsp.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/bpra_pkg.sv
src/bpra_ram.sv
src/bitmap_page_run_allocator_core.sv
dv/bitmap_page_run_allocator_core_test.sv
